>>> src/dcr_pkg.sv
// ----------------------------------------------------------------------------
// dcr_pkg
// Shared constants, register codes and types of the depth-to-color
// registration pipeline.
// ----------------------------------------------------------------------------
package dcr_pkg;

    // frame geometry
    localparam int FRAME_WIDTH  = 640;
    localparam int FRAME_HEIGHT = 480;

    // field widths
    localparam int COL_W       = 10;
    localparam int ROW_W       = 9;
    localparam int DEPTH_W     = 16;
    localparam int COEF_W      = 32;
    localparam int CFG_INDEX_W = 4;

    // exact products col*z and row*z
    localparam int XZ_W = COL_W + DEPTH_W;
    localparam int YZ_W = ROW_W + DEPTH_W;

    // numerator is a signed Q.16 sum, denominator a signed Q.30 sum
    localparam int NUM_W     = 60;
    localparam int NUM_MAG_W = NUM_W - 1;
    localparam int DEN_W     = 48;
    localparam int DEN_MAG_W = DEN_W - 1;

    // quotient is (num * 2^14) / den; only enough bits for a frame position
    localparam int FRAC_SHIFT      = 14;
    localparam int FRAME_DIM_MAX   = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
    localparam int QUOT_BITS_FRAME = $clog2(FRAME_DIM_MAX);
    localparam int QUOT_BITS       = (QUOT_BITS_FRAME > COL_W) ? QUOT_BITS_FRAME : COL_W;
    localparam int QUOT_SHIFT      = FRAC_SHIFT - QUOT_BITS;

    // fixed denominator row, Q2.30
    localparam logic signed [DEN_W-1:0] DEN_C_XZ  = -48'sd3304;
    localparam logic signed [DEN_W-1:0] DEN_C_YZ  = 48'sd3698;
    localparam logic signed [DEN_W-1:0] DEN_C_Z   = 48'sd1073870673;
    localparam logic signed [DEN_W-1:0] DEN_C_ONE = 48'sd338193241;

    // register reset values, Q15.16
    localparam logic signed [COEF_W-1:0] U_COEF_COL_RST   = 32'sd58672;
    localparam logic signed [COEF_W-1:0] U_COEF_ROW_RST   = -32'sd63;
    localparam logic signed [COEF_W-1:0] U_COEF_DEPTH_RST = 32'sd1593003;
    localparam logic signed [COEF_W-1:0] U_OFFSET_RST     = -32'sd849084416;
    localparam logic signed [COEF_W-1:0] V_COEF_COL_RST   = 32'sd85;
    localparam logic signed [COEF_W-1:0] V_COEF_ROW_RST   = 32'sd58789;
    localparam logic signed [COEF_W-1:0] V_COEF_DEPTH_RST = 32'sd729462;
    localparam logic signed [COEF_W-1:0] V_OFFSET_RST     = 32'sd1447802;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_U_COEF_COL,
        CFG_U_COEF_ROW,
        CFG_U_COEF_DEPTH,
        CFG_U_OFFSET,
        CFG_V_COEF_COL,
        CFG_V_COEF_ROW,
        CFG_V_COEF_DEPTH,
        CFG_V_OFFSET
    } t_cfg_reg;

    // sideband that rides along the divider stages
    typedef struct packed {
        logic               ok;
        logic               neg_u;
        logic               neg_v;
        logic [DEPTH_W-1:0] depth;
    } t_div_side;

endpackage

>>> src/dcr_pix_if.sv
// ----------------------------------------------------------------------------
// dcr_pix_if
// Depth pixel request channel: valid/ready with column, row and depth.
// ----------------------------------------------------------------------------
interface dcr_pix_if;
    logic                        valid;
    logic                        ready;
    logic [dcr_pkg::COL_W-1:0]   pixel_col;
    logic [dcr_pkg::ROW_W-1:0]   pixel_row;
    logic [dcr_pkg::DEPTH_W-1:0] depth_in;

    modport source (output valid, output pixel_col, output pixel_row, output depth_in,
                    input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, input depth_in,
                    output ready);
endinterface

>>> src/dcr_res_if.sv
// ----------------------------------------------------------------------------
// dcr_res_if
// Registration result channel: valid/ready with target position and depth.
// ----------------------------------------------------------------------------
interface dcr_res_if;
    logic                        valid;
    logic                        ready;
    logic [dcr_pkg::COL_W-1:0]   target_col;
    logic [dcr_pkg::ROW_W-1:0]   target_row;
    logic [dcr_pkg::DEPTH_W-1:0] depth_out;
    logic                        write_valid;

    modport source (output valid, output target_col, output target_row, output depth_out,
                    output write_valid, input ready);
    modport sink   (input valid, input target_col, input target_row, input depth_out,
                    input write_valid, output ready);
endinterface

>>> src/dcr_cfg_if.sv
// ----------------------------------------------------------------------------
// dcr_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface dcr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dcr_pkg::CFG_INDEX_W-1:0] index;
    logic [dcr_pkg::COEF_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/dcr_div_pipe.sv
// ----------------------------------------------------------------------------
// dcr_div_pipe
// Pipelined restoring divider for the u and v lanes against a shared
// denominator, one quotient bit per stage, with a range check up front.
// ----------------------------------------------------------------------------
module dcr_div_pipe (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_valid,
    input  logic [dcr_pkg::NUM_MAG_W-1:0]     i_num_u,
    input  logic [dcr_pkg::NUM_MAG_W-1:0]     i_num_v,
    input  logic [dcr_pkg::DEN_MAG_W-1:0]     i_den,
    input  dcr_pkg::t_div_side                i_side,
    output logic                              o_valid,
    output logic [dcr_pkg::QUOT_BITS-1:0]     o_quot_u,
    output logic [dcr_pkg::QUOT_BITS-1:0]     o_quot_v,
    output dcr_pkg::t_div_side                o_side
);

    localparam int STAGES = dcr_pkg::QUOT_BITS + 1;
    localparam int SH_W   = dcr_pkg::NUM_MAG_W + dcr_pkg::QUOT_SHIFT;
    localparam int REM_W  = dcr_pkg::DEN_MAG_W;

    logic                          r_valid  [STAGES];
    logic [REM_W-1:0]              r_rem_u  [STAGES];
    logic [REM_W-1:0]              r_rem_v  [STAGES];
    logic [dcr_pkg::QUOT_BITS-1:0] r_quot_u [STAGES];
    logic [dcr_pkg::QUOT_BITS-1:0] r_quot_v [STAGES];
    logic [REM_W-1:0]              r_den    [STAGES];
    dcr_pkg::t_div_side            r_side   [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [REM_W-1:0]              n_rem_u;
        logic [REM_W-1:0]              n_rem_v;
        logic [dcr_pkg::QUOT_BITS-1:0] n_quot_u;
        logic [dcr_pkg::QUOT_BITS-1:0] n_quot_v;
        logic [REM_W-1:0]              n_den;
        dcr_pkg::t_div_side            n_side;
        logic                          n_valid;

        if (k == 0) begin : g_init
            logic [SH_W-1:0] w_sh_u;
            logic [SH_W-1:0] w_sh_v;
            logic            w_ovf_u;
            logic            w_ovf_v;

            // quotient fits the bit budget only when the shifted numerator is below den
            always_comb begin
                w_sh_u   = SH_W'(i_num_u) << dcr_pkg::QUOT_SHIFT;
                w_sh_v   = SH_W'(i_num_v) << dcr_pkg::QUOT_SHIFT;
                w_ovf_u  = w_sh_u >= SH_W'(i_den);
                w_ovf_v  = w_sh_v >= SH_W'(i_den);
                n_valid  = i_valid;
                n_rem_u  = w_sh_u[REM_W-1:0];
                n_rem_v  = w_sh_v[REM_W-1:0];
                n_quot_u = '0;
                n_quot_v = '0;
                n_den    = i_den;
                n_side   = i_side;
                n_side.ok = i_side.ok && !w_ovf_u && !w_ovf_v;
            end
        end else begin : g_step
            logic [REM_W:0]   w_trial_u;
            logic [REM_W:0]   w_trial_v;
            logic [REM_W:0]   w_diff_u;
            logic [REM_W:0]   w_diff_v;
            logic             w_ge_u;
            logic             w_ge_v;

            always_comb begin
                w_trial_u = {r_rem_u[k-1], 1'b0};
                w_trial_v = {r_rem_v[k-1], 1'b0};
                w_diff_u  = w_trial_u - {1'b0, r_den[k-1]};
                w_diff_v  = w_trial_v - {1'b0, r_den[k-1]};
                w_ge_u    = w_trial_u >= {1'b0, r_den[k-1]};
                w_ge_v    = w_trial_v >= {1'b0, r_den[k-1]};
                n_valid   = r_valid[k-1];
                n_rem_u   = w_ge_u ? w_diff_u[REM_W-1:0] : w_trial_u[REM_W-1:0];
                n_rem_v   = w_ge_v ? w_diff_v[REM_W-1:0] : w_trial_v[REM_W-1:0];
                n_quot_u  = {r_quot_u[k-1][dcr_pkg::QUOT_BITS-2:0], w_ge_u};
                n_quot_v  = {r_quot_v[k-1][dcr_pkg::QUOT_BITS-2:0], w_ge_v};
                n_den     = r_den[k-1];
                n_side    = r_side[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_adv) begin
                r_valid[k] <= n_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem_u[k]  <= n_rem_u;
                r_rem_v[k]  <= n_rem_v;
                r_quot_u[k] <= n_quot_u;
                r_quot_v[k] <= n_quot_v;
                r_den[k]    <= n_den;
                r_side[k]   <= n_side;
            end
        end
    end

    assign o_valid  = r_valid[STAGES-1];
    assign o_quot_u = r_quot_u[STAGES-1];
    assign o_quot_v = r_quot_v[STAGES-1];
    assign o_side   = r_side[STAGES-1];

endmodule

>>> src/depth_to_color_registration.sv
// ----------------------------------------------------------------------------
// depth_to_color_registration
// Maps a depth pixel into color-camera coordinates through a projective row
// set: 5 arithmetic stages, QUOT_BITS+1 divider stages and an output register.
// Throughput is one pixel per cycle; the divider retires one quotient bit per
// stage, which sets the pipeline depth. The whole pipe holds while a result waits.
// Reset (synchronous, active low) empties the pipe and loads the default matrix.
// ----------------------------------------------------------------------------
module depth_to_color_registration (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dcr_pix_if.sink      i_pix,
    dcr_cfg_if.sink      i_cfg,
    dcr_res_if.source    o_res
);

    // configuration registers
    logic signed [dcr_pkg::COEF_W-1:0] r_u_coef_col;
    logic signed [dcr_pkg::COEF_W-1:0] r_u_coef_row;
    logic signed [dcr_pkg::COEF_W-1:0] r_u_coef_depth;
    logic signed [dcr_pkg::COEF_W-1:0] r_u_offset;
    logic signed [dcr_pkg::COEF_W-1:0] r_v_coef_col;
    logic signed [dcr_pkg::COEF_W-1:0] r_v_coef_row;
    logic signed [dcr_pkg::COEF_W-1:0] r_v_coef_depth;
    logic signed [dcr_pkg::COEF_W-1:0] r_v_offset;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_coef_col   <= dcr_pkg::U_COEF_COL_RST;
            r_u_coef_row   <= dcr_pkg::U_COEF_ROW_RST;
            r_u_coef_depth <= dcr_pkg::U_COEF_DEPTH_RST;
            r_u_offset     <= dcr_pkg::U_OFFSET_RST;
            r_v_coef_col   <= dcr_pkg::V_COEF_COL_RST;
            r_v_coef_row   <= dcr_pkg::V_COEF_ROW_RST;
            r_v_coef_depth <= dcr_pkg::V_COEF_DEPTH_RST;
            r_v_offset     <= dcr_pkg::V_OFFSET_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                dcr_pkg::CFG_U_COEF_COL:   r_u_coef_col   <= $signed(i_cfg.data);
                dcr_pkg::CFG_U_COEF_ROW:   r_u_coef_row   <= $signed(i_cfg.data);
                dcr_pkg::CFG_U_COEF_DEPTH: r_u_coef_depth <= $signed(i_cfg.data);
                dcr_pkg::CFG_U_OFFSET:     r_u_offset     <= $signed(i_cfg.data);
                dcr_pkg::CFG_V_COEF_COL:   r_v_coef_col   <= $signed(i_cfg.data);
                dcr_pkg::CFG_V_COEF_ROW:   r_v_coef_row   <= $signed(i_cfg.data);
                dcr_pkg::CFG_V_COEF_DEPTH: r_v_coef_depth <= $signed(i_cfg.data);
                dcr_pkg::CFG_V_OFFSET:     r_v_offset     <= $signed(i_cfg.data);
                default: ;
            endcase
        end
    end

    // global advance: every stage moves when the output register is free
    logic w_adv;
    logic r_out_valid;

    assign w_adv       = !r_out_valid || o_res.ready;
    assign i_pix.ready = w_adv;

    // stage 1: col*z, row*z
    logic                          r1_valid;
    logic [dcr_pkg::XZ_W-1:0]      r1_xz;
    logic [dcr_pkg::YZ_W-1:0]      r1_yz;
    logic [dcr_pkg::DEPTH_W-1:0]   r1_z;

    // stage 2: weighted products
    logic                          r2_valid;
    logic signed [dcr_pkg::NUM_W-1:0] r2_pu_col, r2_pu_row, r2_pu_z;
    logic signed [dcr_pkg::NUM_W-1:0] r2_pv_col, r2_pv_row, r2_pv_z;
    logic signed [dcr_pkg::DEN_W-1:0] r2_pd_col, r2_pd_row, r2_pd_z;
    logic [dcr_pkg::DEPTH_W-1:0]   r2_z;

    // stage 3: partial sums
    logic                          r3_valid;
    logic signed [dcr_pkg::NUM_W-1:0] r3_ua, r3_ub, r3_va, r3_vb;
    logic signed [dcr_pkg::DEN_W-1:0] r3_da, r3_db;
    logic [dcr_pkg::DEPTH_W-1:0]   r3_z;

    // stage 4: full numerators and denominator
    logic                          r4_valid;
    logic signed [dcr_pkg::NUM_W-1:0] r4_un, r4_vn;
    logic signed [dcr_pkg::DEN_W-1:0] r4_dn;
    logic [dcr_pkg::DEPTH_W-1:0]   r4_z;

    // stage 5: magnitudes and divider request
    logic                          r5_valid;
    logic [dcr_pkg::NUM_MAG_W-1:0] r5_num_u, r5_num_v;
    logic [dcr_pkg::DEN_MAG_W-1:0] r5_den;
    dcr_pkg::t_div_side            r5_side;

    logic signed [dcr_pkg::XZ_W:0]    w_xz_s;
    logic signed [dcr_pkg::YZ_W:0]    w_yz_s;
    logic signed [dcr_pkg::DEPTH_W:0] w_z_s;
    logic signed [dcr_pkg::NUM_W-1:0] w_un_neg, w_vn_neg;

    assign w_xz_s   = $signed({1'b0, r1_xz});
    assign w_yz_s   = $signed({1'b0, r1_yz});
    assign w_z_s    = $signed({1'b0, r1_z});
    assign w_un_neg = -r4_un;
    assign w_vn_neg = -r4_vn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= i_pix.valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_xz <= i_pix.pixel_col * i_pix.depth_in;
            r1_yz <= i_pix.pixel_row * i_pix.depth_in;
            r1_z  <= i_pix.depth_in;

            r2_pu_col <= r_u_coef_col * w_xz_s;
            r2_pu_row <= r_u_coef_row * w_yz_s;
            r2_pu_z   <= r_u_coef_depth * w_z_s;
            r2_pv_col <= r_v_coef_col * w_xz_s;
            r2_pv_row <= r_v_coef_row * w_yz_s;
            r2_pv_z   <= r_v_coef_depth * w_z_s;
            r2_pd_col <= dcr_pkg::DEN_C_XZ * w_xz_s;
            r2_pd_row <= dcr_pkg::DEN_C_YZ * w_yz_s;
            r2_pd_z   <= dcr_pkg::DEN_C_Z * w_z_s;
            r2_z      <= r1_z;

            r3_ua <= r2_pu_col + r2_pu_row;
            r3_ub <= r2_pu_z + dcr_pkg::NUM_W'(r_u_offset);
            r3_va <= r2_pv_col + r2_pv_row;
            r3_vb <= r2_pv_z + dcr_pkg::NUM_W'(r_v_offset);
            r3_da <= r2_pd_col + r2_pd_row;
            r3_db <= r2_pd_z + dcr_pkg::DEN_C_ONE;
            r3_z  <= r2_z;

            r4_un <= r3_ua + r3_ub;
            r4_vn <= r3_va + r3_vb;
            r4_dn <= r3_da + r3_db;
            r4_z  <= r3_z;

            r5_num_u <= r4_un[dcr_pkg::NUM_W-1] ? w_un_neg[dcr_pkg::NUM_MAG_W-1:0]
                                                 : r4_un[dcr_pkg::NUM_MAG_W-1:0];
            r5_num_v <= r4_vn[dcr_pkg::NUM_W-1] ? w_vn_neg[dcr_pkg::NUM_MAG_W-1:0]
                                                 : r4_vn[dcr_pkg::NUM_MAG_W-1:0];
            r5_den   <= r4_dn[dcr_pkg::DEN_MAG_W-1:0];
            // zero depth or a non-positive denominator never writes
            r5_side.ok    <= (r4_z != '0) && !r4_dn[dcr_pkg::DEN_W-1] && (r4_dn != '0);
            r5_side.neg_u <= r4_un[dcr_pkg::NUM_W-1];
            r5_side.neg_v <= r4_vn[dcr_pkg::NUM_W-1];
            r5_side.depth <= r4_z;
        end
    end

    // divider
    logic                          w_div_valid;
    logic [dcr_pkg::QUOT_BITS-1:0] w_quot_u, w_quot_v;
    dcr_pkg::t_div_side            w_div_side;

    dcr_div_pipe u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_valid  (r5_valid),
        .i_num_u  (r5_num_u),
        .i_num_v  (r5_num_v),
        .i_den    (r5_den),
        .i_side   (r5_side),
        .o_valid  (w_div_valid),
        .o_quot_u (w_quot_u),
        .o_quot_v (w_quot_v),
        .o_side   (w_div_side)
    );

    // final check and output register
    logic                          w_write;
    logic [dcr_pkg::COL_W-1:0]     r_out_col;
    logic [dcr_pkg::ROW_W-1:0]     r_out_row;
    logic [dcr_pkg::DEPTH_W-1:0]   r_out_depth;
    logic                          r_out_write;

    // a negative quotient that truncates to zero still lands on the frame edge
    always_comb begin
        w_write = w_div_side.ok
               && !(w_div_side.neg_u && (w_quot_u != '0))
               && !(w_div_side.neg_v && (w_quot_v != '0))
               && ({1'b0, w_quot_u} < (dcr_pkg::QUOT_BITS + 1)'(dcr_pkg::FRAME_WIDTH))
               && ({1'b0, w_quot_v} < (dcr_pkg::QUOT_BITS + 1)'(dcr_pkg::FRAME_HEIGHT));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_col   <= w_write ? w_quot_u[dcr_pkg::COL_W-1:0] : '0;
            r_out_row   <= w_write ? w_quot_v[dcr_pkg::ROW_W-1:0] : '0;
            r_out_depth <= w_write ? w_div_side.depth : '0;
            r_out_write <= w_write;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.target_col  = r_out_col;
    assign o_res.target_row  = r_out_row;
    assign o_res.depth_out   = r_out_depth;
    assign o_res.write_valid = r_out_write;

endmodule

>>> src/dcr_checker.sv
// ----------------------------------------------------------------------------
// dcr_checker
// Port-level checks on the result channel of the registration pipeline.
// ----------------------------------------------------------------------------
module dcr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_res_valid,
    input logic                        i_res_ready,
    input logic [dcr_pkg::COL_W-1:0]   i_target_col,
    input logic [dcr_pkg::ROW_W-1:0]   i_target_row,
    input logic [dcr_pkg::DEPTH_W-1:0] i_depth_out,
    input logic                        i_write_valid
);

    // pipe is empty right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        ($past(i_rst_n) == 1'b0) |-> !i_res_valid)
        else $error("result valid right after reset");

    a_write_has_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_write_valid) |-> (i_depth_out != '0))
        else $error("write with zero depth");

    a_write_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_write_valid) |->
            ((32'(i_target_col) < dcr_pkg::FRAME_WIDTH)
             && (32'(i_target_row) < dcr_pkg::FRAME_HEIGHT)))
        else $error("write target outside the frame");

    a_nowrite_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_write_valid) |->
            ((i_target_col == '0) && (i_target_row == '0) && (i_depth_out == '0)))
        else $error("dropped result carries nonzero fields");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_target_col) && $stable(i_target_row)
             && $stable(i_depth_out) && $stable(i_write_valid)))
        else $error("stalled result changed");

endmodule

bind depth_to_color_registration dcr_checker u_dcr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_target_col  (o_res.target_col),
    .i_target_row  (o_res.target_row),
    .i_depth_out   (o_res.depth_out),
    .i_write_valid (o_res.write_valid)
);
